// ----- hdl/tkc_pkg.sv -----
`timescale 1ns / 1ps
package tkc_pkg;

  localparam int unsigned CacheEntriesDef = 16;
  localparam int unsigned TokenBytes      = 7;
  localparam int unsigned TokW            = 56;
  localparam int unsigned LenW            = 3;
  localparam int unsigned FlagW           = 8;
  localparam int unsigned SlotW           = 6;
  localparam int unsigned PeriodReset     = 10;

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_FILL   = 2'd1,
    ACT_SYNC   = 2'd2,
    ACT_RESYNC = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    KIND_LOOKUP  = 2'd0,
    KIND_FILL    = 2'd1,
    KIND_REQUEST = 2'd2,
    KIND_DONE    = 2'd3
  } kind_e;

  typedef struct packed {
    logic [TokW-1:0]  tok;
    logic [LenW-1:0]  len;
    logic [FlagW-1:0] perm;
    logic [7:0]       cnt;
    logic [7:0]       cd;
  } entry_t;

  localparam int unsigned EntryW = $bits(entry_t);

  // Byte mask covering the first min(len, TokenBytes) bytes.
  function automatic logic [TokW-1:0] tok_mask(input logic [LenW-1:0] len);
    logic [TokW-1:0] m;
    m = '0;
    for (int b = 0; b < TokW / 8; b++) begin
      if ((b < int'(len)) && (b < TokenBytes)) begin
        m[8*b +: 8] = 8'hFF;
      end
    end
    return m;
  endfunction

endpackage

// ----- hdl/tkc_mem.sv -----
`timescale 1ns / 1ps
module tkc_mem #(
  parameter int unsigned Depth = tkc_pkg::CacheEntriesDef,
  parameter int unsigned AddrW = 4
) (
  input  logic                      clk_i,
  input  logic                      rd_en_i,
  input  logic [AddrW-1:0]          rd_addr_i,
  output logic [tkc_pkg::EntryW-1:0] rd_data_o,
  input  logic                      wr_en_i,
  input  logic [AddrW-1:0]          wr_addr_i,
  input  logic [tkc_pkg::EntryW-1:0] wr_data_i
);
  import tkc_pkg::*;

  logic [EntryW-1:0] mem [Depth];
  logic [EntryW-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- hdl/tkc_ctrl.sv -----
`timescale 1ns / 1ps
module tkc_ctrl #(
  parameter int unsigned Entries = tkc_pkg::CacheEntriesDef,
  parameter int unsigned AddrW   = 4,
  parameter int unsigned CntW    = 5
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [7:0]                  period_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [1:0]                  action_i,
  input  logic [tkc_pkg::TokW-1:0]    token_value_i,
  input  logic [tkc_pkg::LenW-1:0]    token_length_i,
  input  logic [tkc_pkg::FlagW-1:0]   server_flags_i,
  input  logic                        server_error_i,
  input  logic [tkc_pkg::SlotW-1:0]   target_slot_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [1:0]                  result_kind_o,
  output logic                        hit_o,
  output logic [tkc_pkg::FlagW-1:0]   entry_flags_o,
  output logic [tkc_pkg::SlotW-1:0]   entry_slot_o,
  output logic [tkc_pkg::TokW-1:0]    request_token_o,
  output logic [tkc_pkg::LenW-1:0]    request_length_o,
  output logic                        last_o,
  output logic                        rd_en_o,
  output logic [AddrW-1:0]            rd_addr_o,
  input  logic [tkc_pkg::EntryW-1:0]  rd_data_i,
  output logic                        wr_en_o,
  output logic [AddrW-1:0]            wr_addr_o,
  output logic [tkc_pkg::EntryW-1:0]  wr_data_o
);
  import tkc_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;
  localparam logic [2:0] S_RSR  = 3'd4;
  localparam logic [2:0] S_RSC  = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  typedef struct packed {
    logic [1:0]       kind;
    logic             hit;
    logic [FlagW-1:0] flags;
    logic [SlotW-1:0] slot;
    logic [TokW-1:0]  tok;
    logic [LenW-1:0]  len;
    logic             last;
  } res_t;

  logic [2:0]       state_q, state_d;
  logic [CntW-1:0]  used_q, used_d;
  logic [CntW-1:0]  idx_q, idx_d;
  logic [1:0]       act_q, act_d;
  logic [TokW-1:0]  tok_q, tok_d;
  logic [TokW-1:0]  mask_q, mask_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [FlagW-1:0] flags_q, flags_d;
  logic             err_q, err_d;
  logic [7:0]       min_cnt_q, min_cnt_d;
  logic [AddrW-1:0] min_pos_q, min_pos_d;
  res_t             pend_q, pend_d;
  logic             out_valid_q, out_valid_d;
  res_t             out_q, out_d;

  entry_t           rd_e, wr_e;
  logic             out_free;
  logic             match;
  logic [7:0]       cd_dec;
  logic [AddrW-1:0] pos;

  assign rd_e     = entry_t'(rd_data_i);
  assign out_free = !out_valid_q || !out_stall_i;
  assign match    = (rd_e.len == len_q) && (((rd_e.tok ^ tok_q) & mask_q) == '0);
  assign cd_dec   = rd_e.cd - 8'd1;
  assign pos      = (used_q < CntW'(Entries)) ? used_q[AddrW-1:0] : min_pos_q;

  always_comb begin
    state_d     = state_q;
    used_d      = used_q;
    idx_d       = idx_q;
    act_d       = act_q;
    tok_d       = tok_q;
    mask_d      = mask_q;
    len_d       = len_q;
    flags_d     = flags_q;
    err_d       = err_q;
    min_cnt_d   = min_cnt_q;
    min_pos_d   = min_pos_q;
    pend_d      = pend_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    rd_en_o     = 1'b0;
    rd_addr_o   = idx_q[AddrW-1:0];
    wr_en_o     = 1'b0;
    wr_addr_o   = idx_q[AddrW-1:0];
    wr_e        = rd_e;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d   = action_i;
          mask_d  = tok_mask(token_length_i);
          tok_d   = token_value_i & tok_mask(token_length_i);
          len_d   = token_length_i;
          flags_d = server_flags_i;
          err_d   = server_error_i;
          idx_d   = '0;
          pend_d  = '0;
          pend_d.last = 1'b1;
          if (action_i == ACT_RESYNC) begin
            pend_d.kind = KIND_DONE;
            pend_d.slot = target_slot_i;
            if (target_slot_i >= SlotW'(used_q)) begin
              state_d = S_EMIT;
            end else begin
              idx_d   = CntW'(target_slot_i);
              state_d = S_RSR;
            end
          end else if (action_i == ACT_FILL && (server_error_i || server_flags_i == '0)) begin
            pend_d.kind = KIND_FILL;
            state_d     = S_EMIT;
          end else begin
            state_d = S_RD;
          end
        end
      end
      S_RD: begin
        if (idx_q < used_q) begin
          rd_en_o = 1'b1;
          state_d = S_CMP;
        end else begin
          state_d = S_FIN;
        end
      end
      S_CMP: begin
        priority case (act_q)
          ACT_LOOKUP: begin
            if (match) begin
              wr_en_o = 1'b1;
              if (rd_e.perm == '0) begin
                wr_e.len  = '0;
                wr_e.cnt  = '0;
                wr_e.cd   = period_i;
              end else begin
                if (rd_e.cnt != 8'hFF) wr_e.cnt = rd_e.cnt + 8'd1;
                pend_d.hit   = 1'b1;
                pend_d.flags = rd_e.perm;
                pend_d.slot  = SlotW'(idx_q);
              end
              state_d = S_EMIT;
            end else begin
              idx_d   = idx_q + CntW'(1);
              state_d = S_RD;
            end
          end
          ACT_FILL: begin
            if (match) begin
              wr_en_o      = 1'b1;
              wr_e.perm    = flags_q;
              pend_d.kind  = KIND_FILL;
              pend_d.hit   = 1'b1;
              pend_d.flags = flags_q;
              pend_d.slot  = SlotW'(idx_q);
              state_d      = S_EMIT;
            end else begin
              if (idx_q == '0 || rd_e.cnt < min_cnt_q) begin
                min_cnt_d = rd_e.cnt;
                min_pos_d = idx_q[AddrW-1:0];
              end
              idx_d   = idx_q + CntW'(1);
              state_d = S_RD;
            end
          end
          default: begin
            // Sync tick: count down, ask for a recheck on reaching zero.
            wr_e.cd = cd_dec;
            if (cd_dec == 8'd0 && rd_e.len != '0) begin
              if (out_free) begin
                wr_en_o           = 1'b1;
                out_valid_d       = 1'b1;
                out_d             = '0;
                out_d.kind        = KIND_REQUEST;
                out_d.flags       = rd_e.perm;
                out_d.slot        = SlotW'(idx_q);
                out_d.tok         = rd_e.tok;
                out_d.len         = rd_e.len;
                idx_d             = idx_q + CntW'(1);
                state_d           = S_RD;
              end
            end else begin
              wr_en_o = 1'b1;
              idx_d   = idx_q + CntW'(1);
              state_d = S_RD;
            end
          end
        endcase
      end
      S_FIN: begin
        if (act_q == ACT_FILL) begin
          wr_en_o      = 1'b1;
          wr_addr_o    = pos;
          wr_e.tok     = tok_q;
          wr_e.len     = len_q;
          wr_e.perm    = flags_q;
          wr_e.cnt     = 8'd1;
          wr_e.cd      = period_i;
          if (used_q < CntW'(Entries)) used_d = used_q + CntW'(1);
          pend_d.kind  = KIND_FILL;
          pend_d.hit   = 1'b1;
          pend_d.flags = flags_q;
          pend_d.slot  = SlotW'(pos);
        end else if (act_q == ACT_SYNC) begin
          pend_d.kind = KIND_DONE;
        end
        state_d = S_EMIT;
      end
      S_RSR: begin
        rd_en_o = 1'b1;
        state_d = S_RSC;
      end
      S_RSC: begin
        if (rd_e.len != '0) begin
          wr_en_o = 1'b1;
          if (err_q) begin
            wr_e.cd = 8'd1;
          end else if (flags_q == '0) begin
            wr_e.len  = '0;
            wr_e.perm = '0;
            wr_e.cnt  = '0;
            wr_e.cd   = period_i;
          end else begin
            wr_e.perm = flags_q;
            wr_e.cd   = period_i;
          end
          pend_d.hit   = 1'b1;
          pend_d.flags = wr_e.perm;
        end
        state_d = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = pend_q;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign wr_data_o = EntryW'(wr_e);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    act_q     <= act_d;
    tok_q     <= tok_d;
    mask_q    <= mask_d;
    len_q     <= len_d;
    flags_q   <= flags_d;
    err_q     <= err_d;
    min_cnt_q <= min_cnt_d;
    min_pos_q <= min_pos_d;
    pend_q    <= pend_d;
    out_q     <= out_d;
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign result_kind_o    = out_q.kind;
  assign hit_o            = out_q.hit;
  assign entry_flags_o    = out_q.flags;
  assign entry_slot_o     = out_q.slot;
  assign request_token_o  = out_q.tok;
  assign request_length_o = out_q.len;
  assign last_o           = out_q.last;

endmodule

// ----- hdl/access_token_cache_top.sv -----
`timescale 1ns / 1ps
// Access token cache: associative store of up to CacheEntries tokens with
// least-used replacement and a periodic permission recheck.
// Input channel (in_valid_i / in_stall_o): one word per action - lookup,
// fill from server, sync tick or resync answer. A word is taken only while
// the controller is idle, so one action is in flight at a time.
// Output channel (out_valid_o / out_stall_i): one word per result; the
// final word of an action carries last_o. A sync tick yields one resync
// request per live entry whose countdown reaches zero, then a completion.
// Configuration channel (cfg_valid_i / cfg_ready_o): always ready; the word
// sets the resync period, applied when an entry is appended or reloaded.
// Entries live in a single-port-read synchronous RAM; each scanned entry
// takes a read step, then a compare and write-back step. The next word is
// taken in the cycle after the final result is loaded. A stalled receiver
// holds the output register; a sync scan pauses on an entry until its
// request word can be loaded. Reset clears the fill count and control
// state; the RAM is not cleared. Period resets to 10.
module access_token_cache_top #(
  parameter int unsigned CacheEntries = tkc_pkg::CacheEntriesDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [7:0]                cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                action_i,
  input  logic [tkc_pkg::TokW-1:0]  token_value_i,
  input  logic [tkc_pkg::LenW-1:0]  token_length_i,
  input  logic [tkc_pkg::FlagW-1:0] server_flags_i,
  input  logic                      server_error_i,
  input  logic [tkc_pkg::SlotW-1:0] target_slot_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [1:0]                result_kind_o,
  output logic                      hit_o,
  output logic [tkc_pkg::FlagW-1:0] entry_flags_o,
  output logic [tkc_pkg::SlotW-1:0] entry_slot_o,
  output logic [tkc_pkg::TokW-1:0]  request_token_o,
  output logic [tkc_pkg::LenW-1:0]  request_length_o,
  output logic                      last_o
);
  import tkc_pkg::*;

  localparam int unsigned AddrW = (CacheEntries > 1) ? $clog2(CacheEntries) : 1;
  localparam int unsigned CntW  = $clog2(CacheEntries + 1);

  logic [7:0]       period_q;
  logic             rd_en, wr_en;
  logic [AddrW-1:0] rd_addr, wr_addr;
  logic [EntryW-1:0] rd_data, wr_data;

  // Hold the resync period; writes are taken at any time.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= 8'(PeriodReset);
    end else if (cfg_valid_i) begin
      period_q <= cfg_data_i;
    end
  end

  tkc_mem #(
    .Depth (CacheEntries),
    .AddrW (AddrW)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data)
  );

  tkc_ctrl #(
    .Entries (CacheEntries),
    .AddrW   (AddrW),
    .CntW    (CntW)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .period_i         (period_q),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .action_i         (action_i),
    .token_value_i    (token_value_i),
    .token_length_i   (token_length_i),
    .server_flags_i   (server_flags_i),
    .server_error_i   (server_error_i),
    .target_slot_i    (target_slot_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .result_kind_o    (result_kind_o),
    .hit_o            (hit_o),
    .entry_flags_o    (entry_flags_o),
    .entry_slot_o     (entry_slot_o),
    .request_token_o  (request_token_o),
    .request_length_o (request_length_o),
    .last_o           (last_o),
    .rd_en_o          (rd_en),
    .rd_addr_o        (rd_addr),
    .rd_data_i        (rd_data),
    .wr_en_o          (wr_en),
    .wr_addr_o        (wr_addr),
    .wr_data_o        (wr_data)
  );

endmodule
